FILE: rtl/core/utf8_to_utf16_decoder_macros.svh
// Assertion helpers shared by the decoder RTL.
`ifndef UTF8_TO_UTF16_DECODER_MACROS_SVH
`define UTF8_TO_UTF16_DECODER_MACROS_SVH

// Same-cycle implication.
`define U8U16_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define U8U16_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/utf8u16_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package utf8u16_pkg;

	localparam int MAX_UNITS = 4;

	localparam logic [15:0] REPL      = 16'hFFFD;
	localparam logic [15:0] HI_SURR   = 16'hD800;
	localparam logic [15:0] LO_SURR   = 16'hDC00;
	localparam logic [20:0] SUPP_BASE = 21'h10000;
	localparam logic [20:0] CP_MAX    = 21'h10FFFF;
	localparam logic [20:0] SURR_MIN  = 21'h00D800;
	localparam logic [20:0] SURR_MAX  = 21'h00DFFF;
	localparam logic [20:0] MIN_2B    = 21'h000080;
	localparam logic [20:0] MIN_3B    = 21'h000800;

	typedef logic [MAX_UNITS-1:0][15:0] unit_vec_t;

	// Units produced by one accepted word.
	typedef struct packed {
		unit_vec_t   units;
		logic [2:0]  cnt;
		logic        fin;
	} burst_t;

	function automatic logic [2:0] seq_len(input logic [7:0] lead);
		logic [2:0] len;
		len = 3'd0;
		if (lead[7:5] == 3'b110)
			len = 3'd2;
		else if (lead[7:4] == 4'b1110)
			len = 3'd3;
		else if (lead[7:3] == 5'b11110)
			len = 3'd4;
		return len;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/utf8u16_byte_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface utf8u16_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/utf8u16_unit_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface utf8u16_unit_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic        last_of_run;
	logic        final_unit;

	modport source (output valid, output code_unit, output last_of_run, output final_unit,
		input ready);
	modport sink (input valid, input code_unit, input last_of_run, input final_unit,
		output ready);
endinterface

`default_nettype wire

FILE: rtl/core/utf8u16_decode.sv
`timescale 1ns / 1ps
`default_nettype none

`include "utf8_to_utf16_decoder_macros.svh"

module utf8u16_decode (
	input  wire                  clk,
	input  wire                  arst_n,
	utf8u16_byte_if.sink         text,
	input  wire                  take_rdy,
	output logic                 ld,
	output utf8u16_pkg::burst_t  burst
);

	logic [7:0] lead_q;
	logic [5:0] p0_q;
	logic [5:0] p1_q;
	logic [1:0] pc_q;

	logic [7:0] lead_n;
	logic [5:0] p0_n;
	logic [5:0] p1_n;
	logic [1:0] pc_n;

	logic        acc;
	logic [7:0]  b;
	logic        is_cont;
	logic [2:0]  len_cur;
	logic [2:0]  n_pre;
	logic [2:0]  n_main;
	logic [2:0]  n_post;
	logic [15:0] m0;
	logic [15:0] m1;
	logic [20:0] cp;
	logic [20:0] v;
	logic        bad;
	logic        do_lead;

	assign b        = text.data_byte;
	assign is_cont  = (b[7:6] == 2'b10);
	assign len_cur  = utf8u16_pkg::seq_len(lead_q);
	assign acc      = text.valid && text.ready;
	assign text.ready = take_rdy;

	always_comb begin
		cp = 21'd0;
		bad = 1'b1;
		case (len_cur)
			3'd2: begin
				cp = {10'd0, lead_q[4:0], b[5:0]};
				bad = (cp < utf8u16_pkg::MIN_2B);
			end
			3'd3: begin
				cp = {5'd0, lead_q[3:0], p0_q, b[5:0]};
				bad = (cp < utf8u16_pkg::MIN_3B) ||
					((cp >= utf8u16_pkg::SURR_MIN) && (cp <= utf8u16_pkg::SURR_MAX));
			end
			3'd4: begin
				cp = {lead_q[2:0], p0_q, p1_q, b[5:0]};
				bad = (cp < utf8u16_pkg::SUPP_BASE) || (cp > utf8u16_pkg::CP_MAX);
			end
			default: begin
				cp = 21'd0;
				bad = 1'b1;
			end
		endcase
		v = cp - utf8u16_pkg::SUPP_BASE;
	end

	always_comb begin
		n_pre = 3'd0;
		n_main = 3'd0;
		m0 = utf8u16_pkg::REPL;
		m1 = utf8u16_pkg::REPL;
		lead_n = lead_q;
		p0_n = p0_q;
		p1_n = p1_q;
		pc_n = pc_q;
		do_lead = 1'b0;

		if ((pc_q != 2'd0) && is_cont) begin
			if (({1'b0, pc_q} + 3'd1) >= len_cur) begin
				n_main = 3'd1;
				if (bad) begin
					m0 = utf8u16_pkg::REPL;
				end else if (cp < utf8u16_pkg::SUPP_BASE) begin
					m0 = cp[15:0];
				end else begin
					m0 = utf8u16_pkg::HI_SURR | {6'd0, v[19:10]};
					m1 = utf8u16_pkg::LO_SURR | {6'd0, v[9:0]};
					n_main = 3'd2;
				end
				lead_n = 8'd0;
				p0_n = 6'd0;
				p1_n = 6'd0;
				pc_n = 2'd0;
			end else begin
				if (pc_q == 2'd1)
					p0_n = b[5:0];
				else
					p1_n = b[5:0];
				pc_n = pc_q + 2'd1;
			end
		end else begin
			n_pre = {1'b0, pc_q};
			lead_n = 8'd0;
			p0_n = 6'd0;
			p1_n = 6'd0;
			pc_n = 2'd0;
			do_lead = 1'b1;
		end

		if (do_lead) begin
			if (!b[7]) begin
				n_main = 3'd1;
				m0 = {8'd0, b};
			end else if (utf8u16_pkg::seq_len(b) != 3'd0) begin
				lead_n = b;
				pc_n = 2'd1;
			end else begin
				n_main = 3'd1;
				m0 = utf8u16_pkg::REPL;
			end
		end

		n_post = text.final_byte ? {1'b0, pc_n} : 3'd0;
		if (text.final_byte) begin
			lead_n = 8'd0;
			p0_n = 6'd0;
			p1_n = 6'd0;
			pc_n = 2'd0;
		end
	end

	always_comb begin
		logic [2:0] kk;
		burst.cnt = n_pre + n_main + n_post;
		burst.fin = text.final_byte;
		for (int k = 0; k < utf8u16_pkg::MAX_UNITS; k++) begin
			kk = 3'(k);
			if ((kk >= n_pre) && (kk < (n_pre + n_main)))
				burst.units[k] = ((kk - n_pre) == 3'd0) ? m0 : m1;
			else
				burst.units[k] = utf8u16_pkg::REPL;
		end
	end

	assign ld = acc && (burst.cnt != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q <= 8'd0;
			p0_q <= 6'd0;
			p1_q <= 6'd0;
			pc_q <= 2'd0;
		end else if (acc) begin
			lead_q <= lead_n;
			p0_q <= p0_n;
			p1_q <= p1_n;
			pc_q <= pc_n;
		end
	end

	`U8U16_ASSERT_IMPL(a_pc_bound, clk, arst_n, pc_q != 2'd0,
		3'(pc_q) < utf8u16_pkg::seq_len(lead_q), "pending count beyond sequence length")
	`U8U16_ASSERT_IMPL(a_idle_lead, clk, arst_n, pc_q == 2'd0, lead_q == 8'd0,
		"lead held with nothing pending")
	`U8U16_ASSERT_NEXT(a_fin_clear, clk, arst_n, acc && text.final_byte, pc_q == 2'd0,
		"state not cleared after final word")

endmodule

`default_nettype wire

FILE: rtl/core/utf8u16_serial.sv
`timescale 1ns / 1ps
`default_nettype none

`include "utf8_to_utf16_decoder_macros.svh"

module utf8u16_serial (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       ld,
	input  wire utf8u16_pkg::burst_t  burst,
	output logic                      take_rdy,
	utf8u16_unit_if.source            units
);

	utf8u16_pkg::burst_t bst_s1;
	logic                bst_v_q;
	logic [1:0]          idx_q;

	logic        out_v_q;
	logic [15:0] out_unit_q;
	logic        out_last_q;
	logic        out_fin_q;

	logic pop;
	logic is_last;
	logic last_pop;

	assign pop      = bst_v_q && (!out_v_q || units.ready);
	assign is_last  = (({1'b0, idx_q} + 3'd1) == bst_s1.cnt);
	assign last_pop = pop && is_last;
	assign take_rdy = !bst_v_q || last_pop;

	always_ff @(posedge clk) begin
		if (ld)
			bst_s1 <= burst;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bst_v_q <= 1'b0;
			idx_q <= 2'd0;
		end else if (ld) begin
			bst_v_q <= 1'b1;
			idx_q <= 2'd0;
		end else if (last_pop) begin
			bst_v_q <= 1'b0;
		end else if (pop) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (pop) begin
			out_v_q <= 1'b1;
		end else if (units.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_unit_q <= bst_s1.units[idx_q];
			out_last_q <= is_last;
			out_fin_q <= is_last && bst_s1.fin;
		end
	end

	assign units.valid       = out_v_q;
	assign units.code_unit   = out_unit_q;
	assign units.last_of_run = out_last_q;
	assign units.final_unit  = out_fin_q;

	`U8U16_ASSERT_IMPL(a_fin_last, clk, arst_n, out_v_q && out_fin_q, out_last_q,
		"final unit not last of run")
	`U8U16_ASSERT_IMPL(a_cnt_range, clk, arst_n, bst_v_q,
		(bst_s1.cnt != 3'd0) && (bst_s1.cnt <= 3'd4), "burst count out of range")
	`U8U16_ASSERT_NEXT(a_run_gapless, clk, arst_n, out_v_q && units.ready && !out_last_q,
		out_v_q, "gap inside a run of units")

endmodule

`default_nettype wire

FILE: rtl/core/utf8_to_utf16_decoder.sv
// UTF-8 to UTF-16 decoder.
// text:  input channel, one UTF-8 byte per word (data_byte), final_byte set on
//        the last byte of a text.
// units: output channel, one UTF-16 code unit per word; last_of_run marks the
//        last unit caused by an input byte, final_unit the last unit of a text.
// Each byte gives 0 to 4 units (surrogate pairs, 0xFFFD replacements).
// The first unit of a byte passes the per-byte unit buffer and then the output
// register before it is presented on the units channel.
// Throughput: one byte per cycle while each byte gives at most one unit and
// the receiver takes every unit; a byte giving more units holds the input
// until the single-unit output register has drained the per-byte unit buffer.
// Bytes that give no unit bypass the unit buffer.
// Reset clears the pending sequence, the unit buffer and the output register.
// A stalled receiver holds the current unit; the unit buffer still takes one
// more byte that gives units, then text.ready drops. Bytes giving no unit keep
// flowing while the buffer is empty.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_utf16_decoder (
	input  wire              clk,
	input  wire              arst_n,
	utf8u16_byte_if.sink     text,
	utf8u16_unit_if.source   units
);

	logic                ld;
	logic                take_rdy;
	utf8u16_pkg::burst_t burst;

	utf8u16_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.text     (text),
		.take_rdy (take_rdy),
		.ld       (ld),
		.burst    (burst)
	);

	utf8u16_serial u_serial (
		.clk      (clk),
		.arst_n   (arst_n),
		.ld       (ld),
		.burst    (burst),
		.take_rdy (take_rdy),
		.units    (units)
	);

endmodule

`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int N_DIRECTED = 26;
	localparam int N_RANDOM   = 204;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [15:0] REPL_U = utf8u16_pkg::REPL;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        last_of_run;
		logic        final_unit;
	} unit_word_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        final_byte;
		logic        typed;
		logic [2:0]  n;
		logic [15:0] u0, u1, u2, u3;
	} stim_row_t;

	logic clk;
	logic arst_n;

	utf8u16_byte_if text_if ();
	utf8u16_unit_if unit_if ();

	utf8_to_utf16_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.text(text_if.sink),
		.units(unit_if.source)
	);

	// typed rows carry their expected units, the others go through the decoder model
	stim_row_t directed_tbl [N_DIRECTED] = '{
		'{8'h00, 1'b0, 1'b1, 3'd1, 16'h0000, 16'h0, 16'h0, 16'h0},
		'{8'h7F, 1'b0, 1'b1, 3'd1, 16'h007F, 16'h0, 16'h0, 16'h0},
		'{8'h80, 1'b0, 1'b1, 3'd1, REPL_U, 16'h0, 16'h0, 16'h0},
		'{8'hFF, 1'b0, 1'b1, 3'd1, REPL_U, 16'h0, 16'h0, 16'h0},
		'{8'hC3, 1'b0, 1'b1, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{8'hA9, 1'b0, 1'b0, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{8'hF0, 1'b0, 1'b1, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{8'h9F, 1'b0, 1'b1, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{8'h98, 1'b0, 1'b1, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{8'h80, 1'b0, 1'b0, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{8'hC0, 1'b0, 1'b1, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{8'h80, 1'b0, 1'b1, 3'd1, REPL_U, 16'h0, 16'h0, 16'h0},
		'{8'hED, 1'b0, 1'b1, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{8'hA0, 1'b0, 1'b1, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{8'h80, 1'b0, 1'b1, 3'd1, REPL_U, 16'h0, 16'h0, 16'h0},
		'{8'hF4, 1'b0, 1'b1, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{8'h90, 1'b0, 1'b1, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{8'h80, 1'b0, 1'b1, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{8'h80, 1'b0, 1'b1, 3'd1, REPL_U, 16'h0, 16'h0, 16'h0},
		'{8'hF0, 1'b0, 1'b1, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{8'h90, 1'b0, 1'b1, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{8'h80, 1'b0, 1'b1, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{8'hF8, 1'b0, 1'b1, 3'd4, REPL_U, REPL_U, REPL_U, REPL_U},
		'{8'hE1, 1'b0, 1'b1, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0},
		'{8'h41, 1'b1, 1'b1, 3'd2, REPL_U, 16'h0041, 16'h0, 16'h0},
		'{8'hEF, 1'b1, 1'b1, 3'd1, REPL_U, 16'h0, 16'h0, 16'h0}
	};

	unit_word_t unit_q[$];
	logic [7:0] chunk_b[$];
	logic       chunk_f[$];

	logic [7:0]  lead_buf;
	logic [5:0]  pay_buf [2];
	logic [1:0]  held_cnt;
	logic [15:0] next_units [4];
	int          next_n;

	int  err_cnt;
	int  cycles;
	bit  steady;
	unit_word_t want;

	always #10 clk = ~clk;

	function automatic int unsigned lead_len(input logic [7:0] b);
		if (b >= 8'hC0 && b <= 8'hDF)
			return 2;
		if (b >= 8'hE0 && b <= 8'hEF)
			return 3;
		if (b >= 8'hF0 && b <= 8'hF7)
			return 4;
		return 0;
	endfunction

	function automatic void emit_unit(input logic [15:0] u);
		if (next_n < 4) begin
			next_units[next_n] = u;
			next_n++;
		end
	endfunction

	function automatic void emit_cp(input logic [20:0] cp);
		logic [20:0] v;
		if (cp < utf8u16_pkg::SUPP_BASE) begin
			emit_unit(cp[15:0]);
		end else begin
			v = cp - utf8u16_pkg::SUPP_BASE;
			emit_unit(utf8u16_pkg::HI_SURR | {6'd0, v[19:10]});
			emit_unit(utf8u16_pkg::LO_SURR | {6'd0, v[9:0]});
		end
	endfunction

	function automatic void clear_held();
		held_cnt = 2'd0;
		lead_buf = 8'h00;
		pay_buf[0] = 6'd0;
		pay_buf[1] = 6'd0;
	endfunction

	function automatic void drop_held();
		for (int k = 0; k < held_cnt; k++)
			emit_unit(utf8u16_pkg::REPL);
		clear_held();
	endfunction

	function automatic void take_lead(input logic [7:0] b);
		if (b < 8'h80) begin
			emit_unit({8'h00, b});
		end else if (lead_len(b) != 0) begin
			lead_buf = b;
			held_cnt = 2'd1;
		end else begin
			emit_unit(utf8u16_pkg::REPL);
		end
	endfunction

	function automatic void finish_seq(input logic [7:0] tail);
		logic [20:0] cp;
		cp = {5'd0, utf8u16_pkg::REPL};
		case (lead_len(lead_buf))
		2: begin
			cp = {10'd0, lead_buf[4:0], tail[5:0]};
			if (cp < utf8u16_pkg::MIN_2B)
				cp = {5'd0, utf8u16_pkg::REPL};
		end
		3: begin
			cp = {5'd0, lead_buf[3:0], pay_buf[0], tail[5:0]};
			if (cp < utf8u16_pkg::MIN_3B ||
				(cp >= utf8u16_pkg::SURR_MIN && cp <= utf8u16_pkg::SURR_MAX))
				cp = {5'd0, utf8u16_pkg::REPL};
		end
		4: begin
			cp = {lead_buf[2:0], pay_buf[0], pay_buf[1], tail[5:0]};
			if (cp < utf8u16_pkg::SUPP_BASE || cp > utf8u16_pkg::CP_MAX)
				cp = {5'd0, utf8u16_pkg::REPL};
		end
		default: ;
		endcase
		emit_cp(cp);
		clear_held();
	endfunction

	function automatic void decode_word(input logic [7:0] b, input logic fin);
		next_n = 0;
		if (held_cnt != 0) begin
			if (b[7:6] == 2'b10) begin
				if (held_cnt + 1 >= lead_len(lead_buf)) begin
					finish_seq(b);
				end else begin
					pay_buf[held_cnt - 2'd1] = b[5:0];
					held_cnt++;
				end
			end else begin
				drop_held();
				take_lead(b);
			end
		end else begin
			take_lead(b);
		end
		if (fin)
			drop_held();
	endfunction

	function automatic void queue_units(input logic fin);
		unit_word_t w;
		for (int k = 0; k < next_n; k++) begin
			w = {next_units[k], k == next_n - 1, (k == next_n - 1) && fin};
			unit_q.insert(unit_q.size(), w);
		end
	endfunction

	function automatic void add_byte(input logic [7:0] b);
		chunk_b.insert(chunk_b.size(), b);
	endfunction

	function automatic void push_cp(input logic [20:0] cp);
		if (cp < 21'h80) begin
			add_byte(cp[7:0]);
		end else if (cp < 21'h800) begin
			add_byte({3'b110, cp[10:6]});
			add_byte({2'b10, cp[5:0]});
		end else if (cp < 21'h10000) begin
			add_byte({4'b1110, cp[15:12]});
			add_byte({2'b10, cp[11:6]});
			add_byte({2'b10, cp[5:0]});
		end else begin
			add_byte({5'b11110, cp[20:18]});
			add_byte({2'b10, cp[17:12]});
			add_byte({2'b10, cp[11:6]});
			add_byte({2'b10, cp[5:0]});
		end
	endfunction

	function automatic void build_chunk();
		logic [7:0]  lead;
		int unsigned need;
		int unsigned kind;
		chunk_b.delete();
		chunk_f.delete();
		kind = $urandom_range(0, 15);
		if (kind <= 3) begin
			push_cp(21'($urandom_range(0, 8'h7F)));
		end else if (kind <= 6) begin
			push_cp(21'($urandom_range(21'h80, 21'h7FF)));
		end else if (kind <= 9) begin
			push_cp(21'($urandom_range(21'h800, 21'hFFFF)));
		end else if (kind <= 11) begin
			push_cp(21'($urandom_range(21'h10000, 21'h10FFFF)));
		end else if (kind == 12) begin
			// any lead with a full tail: overlong and out of range show up here
			lead = 8'($urandom_range(8'hC0, 8'hF7));
			add_byte(lead);
			for (int k = 1; k < lead_len(lead); k++)
				add_byte(8'($urandom_range(8'h80, 8'hBF)));
		end else if (kind == 13) begin
			lead = 8'($urandom_range(8'hC2, 8'hF4));
			need = lead_len(lead) - 1;
			add_byte(lead);
			repeat ($urandom_range(0, need - 1))
				add_byte(8'($urandom_range(8'h80, 8'hBF)));
		end else if (kind == 14) begin
			add_byte(8'($urandom_range(0, 255)));
		end else begin
			case ($urandom_range(0, 8))
			0: push_cp(21'h7F);
			1: push_cp(21'h80);
			2: push_cp(21'h7FF);
			3: push_cp(21'h800);
			4: push_cp(21'hD7FF);
			5: push_cp(21'hE000);
			6: push_cp(21'hFFFF);
			7: push_cp(21'h10000);
			default: push_cp(21'h10FFFF);
			endcase
		end
		foreach (chunk_b[k])
			chunk_f.insert(chunk_f.size(), 1'b0);
		if ($urandom_range(0, 5) == 0)
			chunk_f[chunk_f.size() - 1] = 1'b1;
		else if ($urandom_range(0, 19) == 0)
			chunk_f[$urandom_range(0, chunk_f.size() - 1)] = 1'b1;
	endfunction

	task automatic send_word(input logic [7:0] b, input logic fin, input bit drain);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 14);
		repeat (gap) begin
			@(negedge clk);
			text_if.valid <= 1'b0;
		end
		if (drain) begin
			@(negedge clk);
			text_if.valid <= 1'b0;
			while (unit_q.size() != 0)
				@(negedge clk);
		end
		@(negedge clk);
		text_if.valid <= 1'b1;
		text_if.data_byte <= b;
		text_if.final_byte <= fin;
		do
			@(posedge clk);
		while (!text_if.ready);
	endtask

	task automatic report(input string field, input logic [15:0] exp_v, input logic [15:0] got_v);
		err_cnt++;
		$display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_v, got_v);
	endtask

	always @(posedge clk) begin
		if (arst_n && unit_if.valid && unit_if.ready) begin
			if (unit_q.size() == 0) begin
				err_cnt++;
				$display("%0t: unexpected word, expected none, got %h", $time,
					unit_if.code_unit);
			end else begin
				want = unit_q.pop_front();
				if (unit_if.code_unit !== want.code_unit)
					report("code_unit", want.code_unit, unit_if.code_unit);
				if (unit_if.last_of_run !== want.last_of_run)
					report("last_of_run", 16'(want.last_of_run), 16'(unit_if.last_of_run));
				if (unit_if.final_unit !== want.final_unit)
					report("final_unit", 16'(want.final_unit), 16'(unit_if.final_unit));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 14);
			repeat (stall) begin
				@(negedge clk);
				unit_if.ready <= 1'b0;
			end
			@(negedge clk);
			unit_if.ready <= 1'b1;
			do
				@(posedge clk);
			while (!unit_if.valid);
		end
	end

	initial begin
		stim_row_t   row;
		logic [15:0] tu [4];
		int          sent;
		bit          drained;
		clk = 1'b0;
		arst_n = 1'b0;
		text_if.valid = 1'b0;
		text_if.data_byte = 8'h00;
		text_if.final_byte = 1'b0;
		unit_if.ready = 1'b0;
		err_cnt = 0;
		cycles = 0;
		steady = 1'b0;
		clear_held();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_DIRECTED; i++) begin
			row = directed_tbl[i];
			send_word(row.data_byte, row.final_byte, 1'b0);
			decode_word(row.data_byte, row.final_byte);
			if (row.typed) begin
				tu = '{row.u0, row.u1, row.u2, row.u3};
				next_n = int'(row.n);
				for (int k = 0; k < 4; k++)
					next_units[k] = tu[k];
			end
			queue_units(row.final_byte);
		end

		sent = 0;
		drained = 1'b0;
		while (sent < N_RANDOM) begin
			build_chunk();
			foreach (chunk_b[k]) begin
				steady = (sent >= 120 && sent < 170);
				send_word(chunk_b[k], chunk_f[k], k == 0 && sent >= 100 && !drained);
				if (k == 0 && sent >= 100)
					drained = 1'b1;
				decode_word(chunk_b[k], chunk_f[k]);
				queue_units(chunk_f[k]);
				sent++;
			end
		end
		steady = 1'b0;
		@(negedge clk);
		text_if.valid <= 1'b0;

		while (unit_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (err_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
